### hw/rtl/assert_macros.svh
// Assertion helpers for the matcher checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds after reset is released.
`define CHK_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("check failed");

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### hw/rtl/gpm_pkg.sv
package gpm_pkg;
  localparam int PatternDepth = 64;
  localparam int SubjectDepth = 256;
  localparam int PAW = $clog2(PatternDepth);
  localparam int SAW = $clog2(SubjectDepth);
  localparam int PLW = PAW + 1;
  localparam int SLW = SAW + 1;

  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_ESC   = 8'h5C;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_SUBJECT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic            wr_pat;
    logic            wr_sub;
    logic            new_job;
    logic            clear;
    logic            rd_pat;   // issue pattern read at p_addr
    logic            rd_sub;   // issue subject read at s_addr
    logic [PLW-1:0]  p_addr;
    logic [7:0]      wdata;
  } gpm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic            ovf;
    logic            pat_closed;
    logic [8:0]      pat_q;    // 256 = end
    logic [8:0]      sub_q;
  } gpm_sts_t;
endpackage

### hw/rtl/gpm_datapath.sv
module gpm_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_last_byte,
  input  gpm_pkg::gpm_cmd_t cmd,
  input  logic [gpm_pkg::SLW-1:0] s_addr,
  output gpm_pkg::gpm_sts_t sts
);
  import gpm_pkg::*;

  logic [7:0] pmem [PatternDepth];
  logic [7:0] smem [SubjectDepth];
  logic [PLW-1:0] plen_r, plen_nxt;
  logic [SLW-1:0] slen_r, slen_nxt;
  logic ovf_r, ovf_nxt, closed_r, closed_nxt;
  logic [7:0] pq_r, sq_r;
  logic pend_r, send_r;

  always_comb begin
    plen_nxt = plen_r;
    slen_nxt = slen_r;
    ovf_nxt = ovf_r;
    closed_nxt = closed_r;
    if (cmd.clear) begin
      plen_nxt = '0;
      slen_nxt = '0;
      ovf_nxt = 1'b0;
      closed_nxt = 1'b0;
    end else if (cmd.wr_pat) begin
      if (cmd.new_job) begin
        slen_nxt = '0;
        ovf_nxt = 1'b0;
        closed_nxt = 1'b0;
      end
      if (cmd.new_job) plen_nxt = PLW'(1);
      else if (plen_r < PLW'(PatternDepth)) plen_nxt = plen_r + 1'b1;
      else ovf_nxt = 1'b1;
      if (in_last_byte) closed_nxt = 1'b1;
    end else if (cmd.wr_sub) begin
      if (slen_r < SLW'(SubjectDepth)) slen_nxt = slen_r + 1'b1;
      else ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
      slen_r <= '0;
      ovf_r <= 1'b0;
      closed_r <= 1'b0;
    end else begin
      plen_r <= plen_nxt;
      slen_r <= slen_nxt;
      ovf_r <= ovf_nxt;
      closed_r <= closed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_pat && (cmd.new_job || plen_r < PLW'(PatternDepth)))
      pmem[cmd.new_job ? '0 : plen_r[PAW-1:0]] <= cmd.wdata;
    if (cmd.wr_sub && slen_r < SLW'(SubjectDepth))
      smem[slen_r[SAW-1:0]] <= cmd.wdata;
    if (cmd.rd_pat) begin
      pq_r <= pmem[cmd.p_addr[PAW-1:0]];
      pend_r <= cmd.p_addr >= plen_r;
    end
    if (cmd.rd_sub) begin
      sq_r <= smem[s_addr[SAW-1:0]];
      send_r <= s_addr >= slen_r;
    end
  end

  always_comb begin
    sts.ovf = ovf_r;
    sts.pat_closed = closed_r;
    sts.pat_q = pend_r ? 9'd256 : {1'b0, pq_r};
    sts.sub_q = send_r ? 9'd256 : {1'b0, sq_r};
  end
endmodule

### hw/rtl/gpm_ctrl.sv
module gpm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_start,
  input  logic              in_operation,
  input  logic [7:0]        in_byte_value,
  input  logic              in_last_byte,
  input  gpm_pkg::gpm_sts_t sts,
  output gpm_pkg::gpm_cmd_t cmd,
  output logic [gpm_pkg::SLW-1:0] s_addr,
  output logic              busy,
  output logic              out_valid,
  output logic              out_matched,
  output logic              out_overflow
);
  import gpm_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0, ST_RD = 4'd1, ST_DEC = 4'd2,
    ST_STAR = 4'd3, ST_CINIT = 4'd4, ST_CA = 4'd5, ST_CDASH = 4'd6,
    ST_CB = 4'd7, ST_CEND = 4'd8, ST_ESC = 4'd9, ST_CMP = 4'd10,
    ST_DONE = 4'd11, ST_BANG = 4'd12;

  logic [3:0] st_r, st_nxt;
  logic [PLW-1:0] p_r, p_nxt, cl_r, cl_nxt, sp_r, sp_nxt, ra_r, ra_nxt;
  logic [SLW-1:0] s_r, s_nxt, ss_r, ss_nxt;
  logic [8:0] c_r, c_nxt, d_r, d_nxt, a_r, a_nxt;
  logic sv_r, sv_nxt, inv_r, inv_nxt, hit_r, hit_nxt, res_r, res_nxt;
  logic ov_r, ov_nxt, val_r, val_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic take, cmp_ok, fail_now;

  assign take = in_start && !busy;
  assign busy = st_r != ST_IDLE;
  assign s_addr = s_r;
  assign cmp_ok = (c_r == d_r);

  // Pattern address chosen per state; subject read at s_r.
  always_comb begin
    cmd = '0;
    cmd.wdata = in_byte_value;
    cmd.p_addr = ra_r;
    if (take && in_operation == OP_PATTERN) begin
      cmd.wr_pat = 1'b1;
      cmd.new_job = sts.pat_closed;
    end
    if (take && in_operation == OP_SUBJECT) cmd.wr_sub = 1'b1;
    if (st_r != ST_IDLE && ph_r == 2'd0) begin
      cmd.rd_pat = 1'b1;
      cmd.rd_sub = 1'b1;
    end
    if (st_r == ST_DONE) cmd.clear = 1'b1;
  end

  // Each read takes phase 0 (issue), phase 1 (data ready).
  always_comb begin
    st_nxt = st_r; p_nxt = p_r; cl_nxt = cl_r; sp_nxt = sp_r; ra_nxt = ra_r;
    s_nxt = s_r; ss_nxt = ss_r; c_nxt = c_r; d_nxt = d_r; a_nxt = a_r;
    sv_nxt = sv_r; inv_nxt = inv_r; hit_nxt = hit_r; res_nxt = res_r;
    ov_nxt = ov_r; val_nxt = 1'b0; ph_nxt = 2'd0; fail_now = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (take && in_operation == OP_SUBJECT && in_last_byte) begin
          p_nxt = '0; s_nxt = '0; ra_nxt = '0; sv_nxt = 1'b0;
          st_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          if (sts.ovf) begin
            res_nxt = 1'b0; ov_nxt = 1'b1; st_nxt = ST_DONE;
          end else begin
            ov_nxt = 1'b0;
            c_nxt = sts.sub_q; d_nxt = sts.pat_q;
            s_nxt = s_r + 1'b1; p_nxt = p_r + 1'b1;
            ra_nxt = p_r + 1'b1;
            st_nxt = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        ph_nxt = 2'd0;
        if (d_r == {1'b0, CH_QUEST}) begin
          if (c_r[8]) begin res_nxt = 1'b0; st_nxt = ST_DONE; end
          else begin ra_nxt = p_r; st_nxt = ST_RD; end
        end else if (d_r == {1'b0, CH_STAR}) st_nxt = ST_STAR;
        else if (d_r == {1'b0, CH_OPEN}) st_nxt = ST_BANG;
        else if (d_r == {1'b0, CH_ESC}) st_nxt = ST_ESC;
        else st_nxt = ST_CMP;
        ph_nxt = (d_r == {1'b0, CH_QUEST}) ? 2'd0 : 2'd0;
      end
      ST_STAR: begin
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else if (sts.pat_q[8]) begin res_nxt = 1'b1; st_nxt = ST_DONE; end
        else begin
          sv_nxt = 1'b1; sp_nxt = p_r; s_nxt = s_r - 1'b1; ss_nxt = s_r - 1'b1;
          ra_nxt = p_r; st_nxt = ST_RD;
        end
      end
      ST_ESC: begin
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          d_nxt = sts.pat_q; p_nxt = p_r + 1'b1; st_nxt = ST_CMP;
        end
      end
      ST_BANG: begin
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          inv_nxt = sts.pat_q == {1'b0, CH_BANG};
          cl_nxt = p_r + PLW'(sts.pat_q == {1'b0, CH_BANG});
          ra_nxt = p_r + PLW'(sts.pat_q == {1'b0, CH_BANG});
          hit_nxt = 1'b0; st_nxt = ST_CINIT;
        end
      end
      ST_CINIT: begin
        // read a at cl
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          a_nxt = sts.pat_q; cl_nxt = cl_r + 1'b1; ra_nxt = cl_r + 1'b1;
          if (sts.pat_q[8]) st_nxt = ST_CMP;
          else st_nxt = ST_CDASH;
        end
      end
      ST_CDASH: begin
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else if (sts.pat_q == {1'b0, CH_DASH}) begin
          ra_nxt = cl_r + 1'b1; st_nxt = ST_CB;
        end else begin
          if (a_r <= c_r && c_r <= a_r) hit_nxt = 1'b1;
          ra_nxt = cl_r; st_nxt = ST_CEND;
        end
      end
      ST_CB: begin
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else if (sts.pat_q == {1'b0, CH_CLOSE}) begin
          if (a_r == c_r) hit_nxt = 1'b1;
          ra_nxt = cl_r; st_nxt = ST_CEND;
        end else if (sts.pat_q[8]) st_nxt = ST_CMP;
        else begin
          if (a_r <= c_r && c_r <= sts.pat_q) hit_nxt = 1'b1;
          cl_nxt = cl_r + PLW'(2); ra_nxt = cl_r + PLW'(2); st_nxt = ST_CEND;
        end
      end
      ST_CEND: begin
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          a_nxt = sts.pat_q; cl_nxt = cl_r + 1'b1; ra_nxt = cl_r + 1'b1;
          if (sts.pat_q == {1'b0, CH_CLOSE}) begin
            if (c_r[8] || hit_r == inv_r) fail_now = 1'b1;
            else begin p_nxt = cl_r + 1'b1; ra_nxt = cl_r + 1'b1; st_nxt = ST_RD; end
          end else if (sts.pat_q[8]) st_nxt = ST_CMP;
          else st_nxt = ST_CDASH;
        end
      end
      ST_CMP: begin
        if (cmp_ok && !fail_now) begin
          if (d_r[8]) begin res_nxt = 1'b1; st_nxt = ST_DONE; end
          else begin ra_nxt = p_r; st_nxt = ST_RD; end
        end else fail_now = 1'b1;
      end
      ST_DONE: begin
        val_nxt = 1'b1; st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (fail_now) begin
      if (c_r[8] || !sv_r) begin res_nxt = 1'b0; st_nxt = ST_DONE; end
      else begin
        p_nxt = sp_r; ra_nxt = sp_r; ss_nxt = ss_r + 1'b1; s_nxt = ss_r + 1'b1;
        st_nxt = ST_RD; ph_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ph_r <= 2'd0; val_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; val_r <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt; cl_r <= cl_nxt; sp_r <= sp_nxt; ra_r <= ra_nxt;
    s_r <= s_nxt; ss_r <= ss_nxt; c_r <= c_nxt; d_r <= d_nxt; a_r <= a_nxt;
    sv_r <= sv_nxt; inv_r <= inv_nxt; hit_r <= hit_nxt; res_r <= res_nxt;
    ov_r <= ov_nxt;
  end

  assign out_valid = val_r;
  assign out_matched = res_r;
  assign out_overflow = ov_r;
endmodule

### hw/rtl/glob_pattern_matcher.sv
// Glob matcher (fnmatch, no flags). Pattern bytes (in_operation 0) load one per
// cycle, then subject bytes (in_operation 1) one per cycle, while busy is low.
// The subject byte with in_last_byte set starts a walk over the two stores:
// each pattern step reads both stores (issue, then registered read data) and
// then decodes; a star or an escape reads the pattern once more, and a class
// reads it for the '!' check and for each class byte. A mismatch after a star
// restarts from the star, so a walk's length grows with the product of the
// pattern and subject lengths. busy is high during the walk. The verdict
// appears on out_matched/out_overflow with out_valid for exactly one cycle; the
// receiver cannot stall it, so it must capture the result in that cycle.
// Overflow forces matched to 0.
module glob_pattern_matcher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [7:0] in_byte_value,
  input  logic       in_last_byte,
  output logic       out_valid,
  output logic       out_matched,
  output logic       out_overflow
);
  import gpm_pkg::*;

  gpm_cmd_t cmd;
  gpm_sts_t sts;
  logic [SLW-1:0] s_addr;

  // sequencer: load commands and match walk
  gpm_ctrl u_ctrl (
    .clk, .rst_n, .in_start(start), .in_operation, .in_byte_value, .in_last_byte,
    .sts, .cmd, .s_addr, .busy, .out_valid, .out_matched, .out_overflow
  );

  // stores, lengths and flags
  gpm_datapath u_dp (
    .clk, .rst_n, .in_last_byte, .cmd, .s_addr, .sts
  );
endmodule

### hw/rtl/gpm_checker.sv
`include "assert_macros.svh"
module gpm_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_matched,
  input logic out_overflow
);
  `CHK_ALWAYS(a_ovf_nomatch, clk, rst_n, !(out_valid && out_overflow && out_matched))
  `CHK_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid)
  `CHK_ALWAYS(a_idle_valid, clk, rst_n, !(out_valid && busy))
endmodule

bind glob_pattern_matcher gpm_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_matched, .out_overflow
);

### verif/glob_pattern_matcher_tb.sv
`timescale 1ns / 1ps

module glob_pattern_matcher_tb;
  import gpm_pkg::*;

  // Cycles with neither an accepted item nor a verdict before giving up.
  // It sits above the longest walk, which grows with pattern length times subject length.
  localparam int IDLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 900;
  localparam int END_MARK = 256;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_operation;
  logic [7:0] in_byte_value;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_matched;
  logic       out_overflow;

  glob_pattern_matcher dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_byte_value(in_byte_value),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_matched  (out_matched),
    .out_overflow (out_overflow)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Verdicts still owed by the block, oldest first.
  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;
  verdict_t pending_verdicts[$];

  int mismatches;
  int idle_cycles;
  int items_sent;
  bit burst_mode;

  // ---------------------------------------------------------------------------
  // Matcher shadow: its own copy of both stores and the job state.
  // ---------------------------------------------------------------------------
  logic [7:0] pat_mem[PatternDepth];
  logic [7:0] sub_mem[SubjectDepth];
  int  pat_len;
  int  sub_len;
  bit  ovf_seen;
  bit  pat_done;

  function automatic int pat_char(int i);
    return (i < pat_len) ? int'(pat_mem[i]) : END_MARK;
  endfunction

  function automatic int sub_char(int i);
    return (i < sub_len) ? int'(sub_mem[i]) : END_MARK;
  endfunction

  // fnmatch walk with one level of backtracking to the latest star.
  function automatic bit glob_walk();
    int p, s, c, d, a, b, cl, star_p, star_s;
    bit have_star, fail, inv, hit, broken;
    p = 0; s = 0; have_star = 0; star_p = 0; star_s = 0;
    forever begin
      c = sub_char(s); s++;
      d = pat_char(p); p++;
      fail = 0;
      if (d == int'(CH_QUEST)) begin
        if (c == END_MARK) return 0;
        continue;
      end
      if (d == int'(CH_STAR)) begin
        if (pat_char(p) == END_MARK) return 1;
        have_star = 1;
        star_p = p;
        s--;
        star_s = s;
        continue;
      end
      if (d == int'(CH_OPEN)) begin
        inv = (pat_char(p) == int'(CH_BANG));
        cl = p + (inv ? 1 : 0);
        a = pat_char(cl); cl++;
        hit = 0; broken = 0;
        do begin
          b = a;
          if (a == END_MARK) begin
            broken = 1;
            break;
          end
          if (pat_char(cl) == int'(CH_DASH) && pat_char(cl + 1) != int'(CH_CLOSE)) begin
            b = pat_char(cl + 1);
            if (b == END_MARK) begin
              broken = 1;
              break;
            end
            cl += 2;
          end
          if (a <= c && c <= b) hit = 1;
          a = pat_char(cl); cl++;
        end while (a != int'(CH_CLOSE));
        if (!broken) begin
          if (c == END_MARK || hit == inv) fail = 1;
          else begin
            p = cl;
            continue;
          end
        end
        // unclosed bracket: compare '[' literally
      end else if (d == int'(CH_ESC)) begin
        d = pat_char(p); p++;
      end
      if (!fail && c == d) begin
        if (d == END_MARK) return 1;
        continue;
      end
      if (c == END_MARK || !have_star) return 0;
      p = star_p;
      star_s++;
      s = star_s;
    end
  endfunction

  // Advance the shadow by one accepted item; reports a verdict on subject end.
  task automatic shadow_step(input logic op, input logic [7:0] b, input logic last,
                             output bit has_verdict, output verdict_t v);
    has_verdict = 0;
    v = '0;
    if (op == OP_PATTERN) begin
      if (pat_done) begin
        pat_len = 0; sub_len = 0; ovf_seen = 0; pat_done = 0;
      end
      if (pat_len < PatternDepth) begin
        pat_mem[pat_len] = b;
        pat_len++;
      end else ovf_seen = 1;
      if (last) pat_done = 1;
    end else begin
      if (sub_len < SubjectDepth) begin
        sub_mem[sub_len] = b;
        sub_len++;
      end else ovf_seen = 1;
      if (last) begin
        has_verdict = 1;
        v.overflow = ovf_seen;
        v.matched = ovf_seen ? 1'b0 : glob_walk();
        pat_len = 0; sub_len = 0; ovf_seen = 0; pat_done = 0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge, acceptance seen on the rising.
  // A typed verdict, where given, replaces the shadow's one in the queue.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [7:0] b, input logic last,
                           input bit typed = 0, input verdict_t typed_v = '0);
    int gap;
    bit hv;
    verdict_t v;
    if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
    gap = burst_mode ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_operation = op;
    in_byte_value = b;
    in_last_byte = last;
    do @(posedge clk); while (busy);
    items_sent++;
    shadow_step(op, b, last, hv, v);
    if (hv) pending_verdicts.push_back(typed ? typed_v : v);
  endtask

  // Verdict checker.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected verdict: matched=%0b overflow=%0b", out_matched, out_overflow);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_matched !== want.matched || out_overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict mismatch: exp matched=%0b overflow=%0b, got matched=%0b overflow=%0b",
                     want.matched, want.overflow, out_matched, out_overflow);
        end
      end
    end
  end

  // Watchdog on cycles where nothing moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Directed table: short jobs around the syntax corners.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic       op;
    logic [7:0] b;
    logic       last;
    bit         typed;
    verdict_t   v;
  } step_t;

  step_t directed[] = '{
    // lone star matches anything, top byte value
    '{OP_PATTERN, CH_STAR, 1'b1, 0, '0},
    '{OP_SUBJECT, 8'hFF,  1'b1, 1, '{1'b1, 1'b0}},
    // unclosed bracket taken as literal '['
    '{OP_PATTERN, CH_OPEN, 1'b1, 0, '0},
    '{OP_SUBJECT, CH_OPEN, 1'b1, 1, '{1'b1, 1'b0}},
    // inverted range class
    '{OP_PATTERN, CH_OPEN, 1'b0, 0, '0},
    '{OP_PATTERN, CH_BANG, 1'b0, 0, '0},
    '{OP_PATTERN, "a",     1'b0, 0, '0},
    '{OP_PATTERN, CH_DASH, 1'b0, 0, '0},
    '{OP_PATTERN, "c",     1'b0, 0, '0},
    '{OP_PATTERN, CH_CLOSE, 1'b1, 0, '0},
    '{OP_SUBJECT, "z",     1'b1, 0, '0},
    // trailing backslash only matches the subject end
    '{OP_PATTERN, CH_ESC,  1'b1, 0, '0},
    '{OP_SUBJECT, 8'h01,   1'b1, 1, '{1'b0, 1'b0}},
    // subject arriving before the pattern is closed
    '{OP_PATTERN, "?",     1'b0, 0, '0},
    '{OP_SUBJECT, "q",     1'b1, 0, '0},
    // ']' first in class is literal, then a reversed range
    '{OP_PATTERN, CH_OPEN, 1'b0, 0, '0},
    '{OP_PATTERN, CH_CLOSE, 1'b0, 0, '0},
    '{OP_PATTERN, "z",     1'b0, 0, '0},
    '{OP_PATTERN, CH_DASH, 1'b0, 0, '0},
    '{OP_PATTERN, "a",     1'b0, 0, '0},
    '{OP_PATTERN, CH_CLOSE, 1'b1, 0, '0},
    '{OP_SUBJECT, CH_CLOSE, 1'b1, 0, '0},
    // class against an empty remainder: "a[b]" vs "a"
    '{OP_PATTERN, "a",     1'b0, 0, '0},
    '{OP_PATTERN, CH_OPEN, 1'b0, 0, '0},
    '{OP_PATTERN, "b",     1'b0, 0, '0},
    '{OP_PATTERN, CH_CLOSE, 1'b1, 0, '0},
    '{OP_SUBJECT, "a",     1'b1, 1, '{1'b0, 1'b0}}
  };

  // Random pattern token: glob syntax, a letter from a tiny alphabet or a random byte.
  function automatic void push_token(ref logic [7:0] q[$]);
    case ($urandom_range(0, 9))
      0, 1, 2: q.push_back(8'("a" + $urandom_range(0, 2)));
      3:       q.push_back(CH_QUEST);
      4, 5:    q.push_back(CH_STAR);
      6: begin
        q.push_back(CH_OPEN);
        if ($urandom_range(0, 1)) q.push_back(CH_BANG);
        q.push_back(8'("a" + $urandom_range(0, 2)));
        if ($urandom_range(0, 1)) begin
          q.push_back(CH_DASH);
          q.push_back(8'("a" + $urandom_range(0, 2)));
        end
        if ($urandom_range(0, 4) != 0) q.push_back(CH_CLOSE);
      end
      7: begin
        q.push_back(CH_ESC);
        q.push_back($urandom_range(0, 1) ? CH_STAR : 8'("a" + $urandom_range(0, 2)));
      end
      default: q.push_back(8'($urandom_range(1, 255)));
    endcase
  endfunction

  task automatic random_job();
    logic [7:0] pq[$];
    logic [7:0] sq[$];
    int plen, slen;
    bit huge, open_pat, subj_first;
    huge = ($urandom_range(0, 29) == 0);
    if (huge) begin
      // around the store limits, plain letters keep the walk short
      plen = $urandom_range(PatternDepth - 2, PatternDepth + 2);
      slen = $urandom_range(SubjectDepth - 2, SubjectDepth + 2);
      for (int i = 0; i < plen; i++) pq.push_back(i == 0 ? CH_STAR : 8'("a"));
      for (int i = 0; i < slen; i++) sq.push_back(8'("a" + $urandom_range(0, 1)));
    end else begin
      plen = $urandom_range(1, 6);
      for (int i = 0; i < plen; i++) push_token(pq);
      slen = $urandom_range(1, 10);
      for (int i = 0; i < slen; i++)
        sq.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(1, 255))
                                                : 8'("a" + $urandom_range(0, 2)));
    end
    open_pat = ($urandom_range(0, 19) == 0);   // pattern never closed
    subj_first = ($urandom_range(0, 29) == 0); // subject before any pattern
    if (!subj_first)
      foreach (pq[i]) send_item(OP_PATTERN, pq[i], !open_pat && i == pq.size() - 1);
    foreach (sq[i]) send_item(OP_SUBJECT, sq[i], i == sq.size() - 1);
  endtask

  initial begin
    verdict_t ovf_v;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_PATTERN;
    in_byte_value = '0;
    in_last_byte = 1'b0;
    pat_len = 0; sub_len = 0; ovf_seen = 0; pat_done = 0;
    mismatches = 0; items_sent = 0; burst_mode = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      send_item(directed[i].op, directed[i].b, directed[i].last, directed[i].typed,
                directed[i].v);

    // pattern one byte past its store: overflow, matched forced low
    ovf_v = '{1'b0, 1'b1};
    for (int i = 0; i <= PatternDepth; i++) send_item(OP_PATTERN, "a", i == PatternDepth);
    send_item(OP_SUBJECT, "a", 1'b1, 1, ovf_v);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) random_job();

    @(negedge clk);
    start = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
